// File: hdl/hcfd_pkg.sv
package hcfd_pkg;

    localparam logic [7:0] CHAR_OPEN  = 8'h5B;
    localparam logic [7:0] CHAR_CLOSE = 8'h5D;

    localparam int QUEUE_DEPTH = 2;
    localparam int NUM_AXES    = 3;

    localparam logic [23:0] HALF_PERIOD_RESET = 24'd5500;

    localparam logic [3:0] POS_IDLE  = 4'd0;
    localparam logic [3:0] POS_FIRST = 4'd1;
    localparam logic [3:0] POS_LAST  = 4'd8;
    localparam logic [3:0] POS_FULL  = 4'd9;

    localparam logic [7:0] OP_SWITCH_FIRST = 8'd1;
    localparam logic [7:0] OP_DRIVER_ON    = 8'd2;
    localparam logic [7:0] OP_DRIVER_LAST  = 8'd2;
    localparam logic [7:0] OP_SPINDLE_LAST = 8'd4;
    localparam logic [7:0] OP_SWITCH_LAST  = 8'd6;
    localparam logic [7:0] OP_MOVE_FIRST   = 8'd7;
    localparam logic [7:0] OP_MOVE_LAST    = 8'd12;
    localparam logic [7:0] OP_PERIOD_FIRST = 8'd13;
    localparam logic [7:0] OP_PERIOD_LAST  = 8'd15;

    typedef enum logic [1:0] {
        ACT_UNKNOWN,
        ACT_SWITCH,
        ACT_MOVE,
        ACT_PERIOD
    } t_action;

    typedef struct packed {
        logic [7:0]  opcode;
        logic [23:0] arg;
        logic        busy;
    } t_frame;

    // bit 4 set when the character is an upper-case hex digit, value below
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        case (c) inside
            [8'h30:8'h39]: r = {1'b1, c[3:0]};
            [8'h41:8'h46]: r = {1'b1, 4'(c[3:0] + 4'd9)};
            default:       r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

// File: hdl/hcfd_front.sv
module hcfd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_byte_valid,
    output logic               o_byte_ready,
    input  logic [7:0]         i_byte,
    input  logic               i_busy,
    input  logic               i_queue_full,
    output logic               o_push,
    output hcfd_pkg::t_frame   o_frame
);

    logic [3:0] r_pos;
    logic [3:0] n_pos;
    logic [3:0] r_digit [8];
    logic       wr_en;
    logic [2:0] wr_idx;
    logic [4:0] hex;
    logic       accept;

    assign o_byte_ready = !i_queue_full;
    assign accept       = i_byte_valid && o_byte_ready;
    assign hex          = hcfd_pkg::hex_digit(i_byte);
    assign wr_idx       = 3'(r_pos - hcfd_pkg::POS_FIRST);

    always_comb begin
        n_pos  = r_pos;
        wr_en  = 1'b0;
        o_push = 1'b0;
        if (accept) begin
            case (r_pos) inside
                hcfd_pkg::POS_IDLE: begin
                    if (i_byte == hcfd_pkg::CHAR_OPEN) begin
                        n_pos = hcfd_pkg::POS_FIRST;
                    end
                end
                [hcfd_pkg::POS_FIRST:hcfd_pkg::POS_LAST]: begin
                    if (i_byte == hcfd_pkg::CHAR_OPEN) begin
                        n_pos = hcfd_pkg::POS_FIRST;
                    end else if (hex[4]) begin
                        wr_en = 1'b1;
                        n_pos = 4'(r_pos + 4'd1);
                    end else begin
                        n_pos = hcfd_pkg::POS_IDLE;
                    end
                end
                hcfd_pkg::POS_FULL: begin
                    if (i_byte == hcfd_pkg::CHAR_CLOSE) begin
                        n_pos  = hcfd_pkg::POS_IDLE;
                        o_push = 1'b1;
                    end
                end
                default: begin
                    n_pos = hcfd_pkg::POS_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= hcfd_pkg::POS_IDLE;
        end else begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_digit[wr_idx] <= hex[3:0];
        end
    end

    assign o_frame.opcode = {r_digit[0], r_digit[1]};
    assign o_frame.arg    = {r_digit[6], r_digit[7], r_digit[4], r_digit[5],
                             r_digit[2], r_digit[3]};
    assign o_frame.busy   = i_busy;

endmodule

// File: hdl/hcfd_queue.sv
module hcfd_queue #(
    parameter int DEPTH = hcfd_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  hcfd_pkg::t_frame   i_frame,
    output logic               o_full,
    output logic               o_valid,
    input  logic               i_pop,
    output hcfd_pkg::t_frame   o_frame
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hcfd_pkg::t_frame r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_frame = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : PW'(r_wr + 1'b1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : PW'(r_rd + 1'b1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= CW'(r_count + 1'b1);
                2'b01:   r_count <= CW'(r_count - 1'b1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_frame;
        end
    end

endmodule

// File: hdl/hcfd_back.sv
module hcfd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  hcfd_pkg::t_frame   i_frame,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_opcode,
    output hcfd_pkg::t_action  o_action,
    output logic [1:0]         o_axis,
    output logic               o_direction,
    output logic [15:0]        o_step_count,
    output logic [23:0]        o_half_period,
    output logic               o_driver_on,
    output logic               o_spindle_on,
    output logic               o_exhaust_on,
    output logic               o_stop_previous,
    output logic               o_ack,
    output logic [23:0]        o_echo_value
);

    logic              r_valid;
    logic              r_drv;
    logic              r_spd;
    logic              r_exh;
    logic [23:0]       r_hp [hcfd_pkg::NUM_AXES];

    logic [7:0]        r_opcode;
    hcfd_pkg::t_action r_action;
    logic [1:0]        r_axis;
    logic              r_dir;
    logic [15:0]       r_steps;
    logic [23:0]       r_half;
    logic              r_stop;
    logic              r_ack;
    logic [23:0]       r_echo;

    logic [7:0]        op;
    logic [7:0]        move_off;
    hcfd_pkg::t_action n_action;
    logic [1:0]        n_axis;
    logic              n_dir;
    logic [15:0]       n_steps;
    logic [23:0]       n_half;
    logic              n_ack;
    logic [23:0]       n_echo;
    logic              n_drv;
    logic              n_spd;
    logic              n_exh;
    logic              hp_wr;

    assign o_pop    = i_valid && (!r_valid || i_ready);
    assign op       = i_frame.opcode;
    assign move_off = 8'(op - hcfd_pkg::OP_MOVE_FIRST);

    always_comb begin
        n_action = hcfd_pkg::ACT_UNKNOWN;
        n_axis   = 2'd0;
        n_dir    = 1'b0;
        n_steps  = 16'd0;
        n_half   = 24'd0;
        n_ack    = 1'b0;
        n_echo   = 24'd0;
        n_drv    = r_drv;
        n_spd    = r_spd;
        n_exh    = r_exh;
        hp_wr    = 1'b0;
        case (op) inside
            [hcfd_pkg::OP_SWITCH_FIRST:hcfd_pkg::OP_SWITCH_LAST]: begin
                n_action = hcfd_pkg::ACT_SWITCH;
                n_ack    = 1'b1;
                if (op <= hcfd_pkg::OP_DRIVER_LAST) begin
                    n_drv = (op == hcfd_pkg::OP_DRIVER_ON);
                end else if (op <= hcfd_pkg::OP_SPINDLE_LAST) begin
                    n_spd = op[0];
                end else begin
                    n_exh = op[0];
                end
            end
            [hcfd_pkg::OP_MOVE_FIRST:hcfd_pkg::OP_MOVE_LAST]: begin
                n_action = hcfd_pkg::ACT_MOVE;
                n_ack    = 1'b1;
                n_axis   = move_off[2:1];
                n_dir    = op[0];
                n_steps  = i_frame.arg[15:0];
                n_half   = r_hp[move_off[2:1]];
                n_echo   = {8'd0, i_frame.arg[15:0]};
            end
            [hcfd_pkg::OP_PERIOD_FIRST:hcfd_pkg::OP_PERIOD_LAST]: begin
                n_action = hcfd_pkg::ACT_PERIOD;
                n_ack    = 1'b1;
                n_axis   = 2'(op - hcfd_pkg::OP_PERIOD_FIRST);
                n_half   = i_frame.arg;
                n_echo   = i_frame.arg;
                hp_wr    = 1'b1;
            end
            default: begin
                n_action = hcfd_pkg::ACT_UNKNOWN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_drv   <= 1'b0;
            r_spd   <= 1'b0;
            r_exh   <= 1'b0;
            for (int i = 0; i < hcfd_pkg::NUM_AXES; i++) begin
                r_hp[i] <= hcfd_pkg::HALF_PERIOD_RESET;
            end
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
                r_drv   <= n_drv;
                r_spd   <= n_spd;
                r_exh   <= n_exh;
                if (hp_wr) begin
                    r_hp[n_axis] <= i_frame.arg;
                end
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_opcode <= op;
            r_action <= n_action;
            r_axis   <= n_axis;
            r_dir    <= n_dir;
            r_steps  <= n_steps;
            r_half   <= n_half;
            r_stop   <= i_frame.busy;
            r_ack    <= n_ack;
            r_echo   <= n_echo;
        end
    end

    assign o_valid         = r_valid;
    assign o_opcode        = r_opcode;
    assign o_action        = r_action;
    assign o_axis          = r_axis;
    assign o_direction     = r_dir;
    assign o_step_count    = r_steps;
    assign o_half_period   = r_half;
    assign o_driver_on     = r_drv;
    assign o_spindle_on    = r_spd;
    assign o_exhaust_on    = r_exh;
    assign o_stop_previous = r_stop;
    assign o_ack           = r_ack;
    assign o_echo_value    = r_echo;

endmodule

// File: hdl/hex_command_frame_decoder.sv
// channel  dir  handshake                  payload
// s        in   i_s_tvalid / o_s_tready     tdata[7:0] rx_byte, tuser[0] executor_busy
// m        out  o_m_tvalid / i_m_tready     tdata 80 bits decoded command, tuser[1:0] action
//
// one byte accepted per cycle unless the frame queue is full
// a closing bracket pushes the frame queue; a pop loads the output register
// the input stalls only when the frame queue is full
// a stalled output holds its word; levels and half-periods change as words enter it
// synchronous active-low reset clears frame position, levels and valid, and sets half-periods to their reset value
module hex_command_frame_decoder #(
    parameter int QUEUE_DEPTH = hcfd_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // rx_byte
    input  logic [0:0]  i_s_tuser,   // executor_busy
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // opcode[7:0] axis[9:8] direction[10] step_count[26:11] half_period[50:27]
    // driver_on[51] spindle_on[52] exhaust_on[53] stop_previous[54] ack[55]
    // echo_value[79:56]
    output logic [79:0] o_m_tdata,
    output logic [1:0]  o_m_tuser    // action
);

    logic              push;
    logic              q_full;
    logic              q_valid;
    logic              pop;
    hcfd_pkg::t_frame  push_frame;
    hcfd_pkg::t_frame  pop_frame;

    logic [7:0]        opcode;
    hcfd_pkg::t_action action;
    logic [1:0]        axis;
    logic              direction;
    logic [15:0]       step_count;
    logic [23:0]       half_period;
    logic              driver_on;
    logic              spindle_on;
    logic              exhaust_on;
    logic              stop_previous;
    logic              ack;
    logic [23:0]       echo_value;

    hcfd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (i_s_tvalid),
        .o_byte_ready (o_s_tready),
        .i_byte       (i_s_tdata),
        .i_busy       (i_s_tuser[0]),
        .i_queue_full (q_full),
        .o_push       (push),
        .o_frame      (push_frame)
    );

    hcfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_frame (push_frame),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_frame (pop_frame)
    );

    hcfd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (q_valid),
        .i_frame         (pop_frame),
        .o_pop           (pop),
        .o_valid         (o_m_tvalid),
        .i_ready         (i_m_tready),
        .o_opcode        (opcode),
        .o_action        (action),
        .o_axis          (axis),
        .o_direction     (direction),
        .o_step_count    (step_count),
        .o_half_period   (half_period),
        .o_driver_on     (driver_on),
        .o_spindle_on    (spindle_on),
        .o_exhaust_on    (exhaust_on),
        .o_stop_previous (stop_previous),
        .o_ack           (ack),
        .o_echo_value    (echo_value)
    );

    assign o_m_tdata = {echo_value, ack, stop_previous, exhaust_on, spindle_on, driver_on,
                        half_period, step_count, direction, axis, opcode};
    assign o_m_tuser = action;

endmodule

// File: hdl/hcfd_checker.sv
module hcfd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [79:0] o_m_tdata,
    input logic [1:0]  o_m_tuser
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("output word changed while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[55] == (o_m_tuser != hcfd_pkg::ACT_UNKNOWN)))
        else $error("ack does not match action");

    a_switch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == hcfd_pkg::ACT_SWITCH || o_m_tuser == hcfd_pkg::ACT_UNKNOWN)
        |-> o_m_tdata[50:8] == '0 && o_m_tdata[79:56] == '0)
        else $error("argument fields set for switch or unknown command");

endmodule

bind hex_command_frame_decoder hcfd_checker u_hcfd_checker (.*);

// File: bench/tb_hex_command_frame_decoder.sv
module tb_hex_command_frame_decoder;

    localparam int RX_ITEMS    = 1800;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_START  = 2000;
    localparam int HOLD_LEN    = 400;
    localparam int DRAIN_WAIT  = 20;

    typedef struct {
        logic [7:0] c;
        logic       busy;
    } t_rx_word;

    typedef struct {
        logic [7:0]        opcode;
        hcfd_pkg::t_action action;
        logic [1:0]        axis;
        logic              direction;
        logic [15:0]       step_count;
        logic [23:0]       half_period;
        logic              driver_on;
        logic              spindle_on;
        logic              exhaust_on;
        logic              stop_previous;
        logic              ack;
        logic [23:0]       echo_value;
    } t_command;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_data = 8'd0;
    logic [0:0]  s_user = 1'b0;
    logic        m_ready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [79:0] o_m_tdata;
    logic [1:0]  o_m_tuser;

    t_rx_word pending_bytes[$];
    t_command expected_commands[$];

    // predictor state
    logic [3:0]  frame_pos;
    logic [3:0]  digits[8];
    logic        driver_lvl;
    logic        spindle_lvl;
    logic        exhaust_lvl;
    logic [23:0] axis_period[hcfd_pkg::NUM_AXES];

    int   errors = 0;
    int   cycle_count = 0;
    int   send_gap = 0;
    int   stall_left = 0;
    logic hold_on = 1'b0;
    logic stim_done = 1'b0;

    hex_command_frame_decoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_data),
        .i_s_tuser  (s_user),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_ready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #6 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (cycle_count[9:8] == 2'b11) begin
            return 0;
        end
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] v);
        if (v < 4'd10) begin
            return 8'h30 + 8'(v);
        end
        return 8'h41 + 8'(v - 4'd10);
    endfunction

    function automatic logic [4:0] digit_of(logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) begin
            return {1'b1, 4'(c - 8'h30)};
        end
        if (c >= 8'h41 && c <= 8'h46) begin
            return {1'b1, 4'(c - 8'h41 + 8'd10)};
        end
        return 5'd0;
    endfunction

    function automatic void reset_predictor();
        frame_pos   = hcfd_pkg::POS_IDLE;
        driver_lvl  = 1'b0;
        spindle_lvl = 1'b0;
        exhaust_lvl = 1'b0;
        for (int i = 0; i < 8; i++) begin
            digits[i] = 4'd0;
        end
        for (int i = 0; i < hcfd_pkg::NUM_AXES; i++) begin
            axis_period[i] = hcfd_pkg::HALF_PERIOD_RESET;
        end
    endfunction

    function automatic void decode_command(logic busy);
        t_command   cmd;
        logic [7:0] op;
        op = {digits[0], digits[1]};
        cmd.opcode        = op;
        cmd.action        = hcfd_pkg::ACT_UNKNOWN;
        cmd.axis          = 2'd0;
        cmd.direction     = 1'b0;
        cmd.step_count    = 16'd0;
        cmd.half_period   = 24'd0;
        cmd.ack           = 1'b0;
        cmd.echo_value    = 24'd0;
        cmd.stop_previous = busy;
        if (op >= hcfd_pkg::OP_SWITCH_FIRST && op <= hcfd_pkg::OP_SWITCH_LAST) begin
            cmd.action = hcfd_pkg::ACT_SWITCH;
            cmd.ack    = 1'b1;
            if (op <= hcfd_pkg::OP_DRIVER_LAST) begin
                driver_lvl = (op == hcfd_pkg::OP_DRIVER_ON);
            end else if (op <= hcfd_pkg::OP_SPINDLE_LAST) begin
                spindle_lvl = op[0];
            end else begin
                exhaust_lvl = op[0];
            end
        end else if (op >= hcfd_pkg::OP_MOVE_FIRST && op <= hcfd_pkg::OP_MOVE_LAST) begin
            cmd.action      = hcfd_pkg::ACT_MOVE;
            cmd.ack         = 1'b1;
            cmd.axis        = 2'((op - hcfd_pkg::OP_MOVE_FIRST) >> 1);
            cmd.direction   = op[0];
            cmd.step_count  = {digits[4], digits[5], digits[2], digits[3]};
            cmd.half_period = axis_period[cmd.axis];
            cmd.echo_value  = {8'd0, cmd.step_count};
        end else if (op >= hcfd_pkg::OP_PERIOD_FIRST && op <= hcfd_pkg::OP_PERIOD_LAST) begin
            cmd.action      = hcfd_pkg::ACT_PERIOD;
            cmd.ack         = 1'b1;
            cmd.axis        = 2'(op - hcfd_pkg::OP_PERIOD_FIRST);
            cmd.half_period = {digits[6], digits[7], digits[4], digits[5],
                               digits[2], digits[3]};
            axis_period[cmd.axis] = cmd.half_period;
            cmd.echo_value  = cmd.half_period;
        end
        cmd.driver_on  = driver_lvl;
        cmd.spindle_on = spindle_lvl;
        cmd.exhaust_on = exhaust_lvl;
        expected_commands.push_back(cmd);
    endfunction

    function automatic void decode_rx_byte(logic [7:0] c, logic busy);
        logic [4:0] d;
        d = digit_of(c);
        if (frame_pos == hcfd_pkg::POS_IDLE) begin
            if (c == hcfd_pkg::CHAR_OPEN) begin
                frame_pos = hcfd_pkg::POS_FIRST;
            end
        end else if (frame_pos <= hcfd_pkg::POS_LAST) begin
            if (c == hcfd_pkg::CHAR_OPEN) begin
                frame_pos = hcfd_pkg::POS_FIRST;
            end else if (!d[4]) begin
                frame_pos = hcfd_pkg::POS_IDLE;
            end else begin
                digits[frame_pos - 4'd1] = d[3:0];
                frame_pos = frame_pos + 4'd1;
            end
        end else if (frame_pos == hcfd_pkg::POS_FULL) begin
            if (c == hcfd_pkg::CHAR_CLOSE) begin
                frame_pos = hcfd_pkg::POS_IDLE;
                decode_command(busy);
            end
        end else begin
            frame_pos = hcfd_pkg::POS_IDLE;
        end
    endfunction

    task automatic push_byte(logic [7:0] c, logic busy);
        t_rx_word w;
        w.c    = c;
        w.busy = busy;
        pending_bytes.push_back(w);
    endtask

    task automatic push_frame(logic [7:0] op, logic [23:0] arg, logic busy, int extras);
        logic [3:0] nib[8];
        logic [7:0] x;
        nib = '{op[7:4], op[3:0], arg[7:4], arg[3:0], arg[15:12], arg[11:8],
                arg[23:20], arg[19:16]};
        push_byte(hcfd_pkg::CHAR_OPEN, 1'($urandom));
        for (int i = 0; i < 8; i++) begin
            push_byte(hex_char(nib[i]), 1'($urandom));
        end
        for (int i = 0; i < extras; i++) begin
            x = 8'($urandom);
            if (x == hcfd_pkg::CHAR_CLOSE) begin
                x = hcfd_pkg::CHAR_OPEN;
            end
            push_byte(x, 1'($urandom));
        end
        push_byte(hcfd_pkg::CHAR_CLOSE, busy);
    endtask

    task automatic build_stimulus();
        int         r;
        int         k;
        logic [7:0] op;
        logic [23:0] arg;
        logic [7:0] c;
        // directed cases
        push_frame(hcfd_pkg::OP_DRIVER_ON, 24'h000000, 1'b1, 0);
        push_frame(hcfd_pkg::OP_MOVE_FIRST, 24'hFFFFFF, 1'b0, 0);
        push_frame(hcfd_pkg::OP_PERIOD_LAST, 24'hFFFFFF, 1'b1, 0);
        push_frame(hcfd_pkg::OP_PERIOD_FIRST, 24'h000000, 1'b0, 0);
        push_frame(8'h00, 24'h123456, 1'b1, 0);
        push_frame(8'hFF, 24'hFFFFFF, 1'b0, 0);
        // restart on open bracket mid-frame
        push_byte(hcfd_pkg::CHAR_OPEN, 1'b0);
        push_byte("1", 1'b0);
        push_byte("2", 1'b0);
        push_frame(8'h03, 24'h00ABCD, 1'b0, 0);
        // early close bracket
        push_byte(hcfd_pkg::CHAR_OPEN, 1'b0);
        push_byte("0", 1'b0);
        push_byte("5", 1'b0);
        push_byte(hcfd_pkg::CHAR_CLOSE, 1'b1);
        // lower-case digit drops the frame
        push_byte(hcfd_pkg::CHAR_OPEN, 1'b0);
        push_byte("0", 1'b0);
        push_byte("a", 1'b0);
        push_byte(hcfd_pkg::CHAR_CLOSE, 1'b0);
        // junk and open bracket ignored after the eighth digit
        push_frame(hcfd_pkg::OP_MOVE_LAST, 24'h0000FF, 1'b1, 2);
        push_frame(hcfd_pkg::OP_SWITCH_LAST, 24'h000000, 1'b0, 1);

        while (pending_bytes.size() < RX_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                op  = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(1, 15))
                                                   : 8'($urandom);
                k   = $urandom_range(0, 9);
                arg = (k == 0) ? 24'hFFFFFF : (k == 1) ? 24'h000000 : 24'($urandom);
                push_frame(op, arg, 1'($urandom),
                           ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
            end else if (r < 80) begin
                push_byte(8'($urandom), 1'($urandom));
            end else if (r < 92) begin
                push_byte(hcfd_pkg::CHAR_OPEN, 1'($urandom));
                k = $urandom_range(0, 7);
                for (int i = 0; i < k; i++) begin
                    push_byte(hex_char(4'($urandom)), 1'($urandom));
                end
                case ($urandom_range(0, 3))
                    0: push_byte(hcfd_pkg::CHAR_CLOSE, 1'($urandom));
                    1: push_byte(8'h61 + 8'($urandom_range(0, 5)), 1'($urandom));
                    2: begin
                        c = 8'($urandom);
                        if (digit_of(c) != 5'd0) begin
                            c = 8'h20;
                        end
                        push_byte(c, 1'($urandom));
                    end
                    default: push_frame(8'($urandom_range(1, 15)), 24'($urandom),
                                        1'($urandom), 0);
                endcase
            end else begin
                k = $urandom_range(1, 5);
                for (int i = 0; i < k; i++) begin
                    push_byte(8'($urandom), 1'($urandom));
                end
            end
        end
    endtask

    function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
        if (exp !== act) begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp, act);
            errors++;
        end
    endfunction

    // cycle count, receiver hold-off and timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        hold_on     <= (cycle_count >= HOLD_START) && (cycle_count < HOLD_START + HOLD_LEN);
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[hex_command_frame_decoder] ERROR");
            $finish;
        end
    end

    // byte driver
    always @(posedge i_clk) begin : drive
        t_rx_word w;
        logic     nv;
        if (!i_rst_n) begin
            s_valid   <= 1'b0;
            stim_done <= 1'b0;
        end else begin
            nv = s_valid;
            if (s_valid && o_s_tready) begin
                decode_rx_byte(s_data, s_user[0]);
            end
            if (!s_valid || o_s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    nv = 1'b0;
                end else if (pending_bytes.size() > 0) begin
                    w = pending_bytes.pop_front();
                    s_data   <= w.c;
                    s_user   <= w.busy;
                    nv       = 1'b1;
                    send_gap = pick_gap();
                end else begin
                    nv = 1'b0;
                end
            end
            s_valid   <= nv;
            stim_done <= !nv && (pending_bytes.size() == 0);
        end
    end

    // command monitor
    always @(posedge i_clk) begin : watch
        t_command cmd;
        logic     nr;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (o_m_tvalid && m_ready) begin
                if (expected_commands.size() == 0) begin
                    $error("unexpected word: tdata %h tuser %h", o_m_tdata, o_m_tuser);
                    errors++;
                end else begin
                    cmd = expected_commands.pop_front();
                    check_field("opcode", cmd.opcode, o_m_tdata[7:0]);
                    check_field("action", cmd.action, o_m_tuser);
                    check_field("axis", cmd.axis, o_m_tdata[9:8]);
                    check_field("direction", cmd.direction, o_m_tdata[10]);
                    check_field("step_count", cmd.step_count, o_m_tdata[26:11]);
                    check_field("half_period", cmd.half_period, o_m_tdata[50:27]);
                    check_field("driver_on", cmd.driver_on, o_m_tdata[51]);
                    check_field("spindle_on", cmd.spindle_on, o_m_tdata[52]);
                    check_field("exhaust_on", cmd.exhaust_on, o_m_tdata[53]);
                    check_field("stop_previous", cmd.stop_previous, o_m_tdata[54]);
                    check_field("ack", cmd.ack, o_m_tdata[55]);
                    check_field("echo_value", cmd.echo_value, o_m_tdata[79:56]);
                end
            end
            if (hold_on) begin
                nr = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                nr = 1'b0;
            end else begin
                nr = 1'b1;
                if ($urandom_range(0, 3) == 0) begin
                    stall_left = pick_gap();
                end
            end
            m_ready <= nr;
        end
    end

    initial begin
        reset_predictor();
        build_stimulus();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (!stim_done) @(posedge i_clk);
        while (expected_commands.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (expected_commands.size() > 0) begin
            $error("%0d expected words never arrived", expected_commands.size());
            errors++;
        end
        if (errors == 0) begin
            $display("[hex_command_frame_decoder] OK");
        end else begin
            $display("[hex_command_frame_decoder] ERROR");
        end
        $finish;
    end

endmodule
